@@ rtl/tfr_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package tfr_pkg;

  localparam int HALF_TURN_STEPS = 4000;
  localparam int TRIG_FRAC_BITS  = 14;

  localparam int QUARTER_STEPS = HALF_TURN_STEPS / 2;
  localparam int PITCH_MAX     = (HALF_TURN_STEPS * 4) / 9;
  localparam int PITCH_MIN     = -((HALF_TURN_STEPS * 5) / 18);
  localparam int WHEEL_MAX     = 4;
  localparam int WHEEL_STEP    = 2;
  localparam int TRIG_ONE      = 1 << TRIG_FRAC_BITS;
  localparam int ROUND_HALF    = 1 << (TRIG_FRAC_BITS - 1);

  localparam int VEC_W   = 32;
  localparam int YAW_W   = 13;
  localparam int PITCH_W = 12;
  localparam int ANG_W   = 14;
  localparam int TRIG_W  = TRIG_FRAC_BITS + 2;
  localparam int ROM_W   = TRIG_FRAC_BITS + 1;
  localparam int ROM_AW  = $clog2(QUARTER_STEPS + 1);
  localparam int PROD_W  = VEC_W + TRIG_W;
  localparam int ACC_W   = PROD_W + 2;

  localparam logic [63:0] PI_HALF_Q31 = 64'd3373259426;

  typedef logic [2:0]                action_t;
  typedef logic [2:0]                mode_t;
  typedef logic [2:0]                wheel_t;
  typedef logic signed [VEC_W-1:0]   vec_t;
  typedef logic signed [YAW_W-1:0]   yaw_t;
  typedef logic signed [PITCH_W-1:0] pitch_t;
  typedef logic signed [TRIG_W-1:0]  trig_t;
  typedef logic [ROM_W-1:0]          sine_rom_t [0:QUARTER_STEPS];

  localparam action_t ACT_TICK       = 3'd0;
  localparam action_t ACT_DEVICE     = 3'd1;
  localparam action_t ACT_MODE       = 3'd2;
  localparam action_t ACT_WHEEL_UP   = 3'd3;
  localparam action_t ACT_WHEEL_DOWN = 3'd4;

  localparam mode_t MODE_STOP  = 3'd0;
  localparam mode_t MODE_RIGHT = 3'd1;
  localparam mode_t MODE_LEFT  = 3'd2;
  localparam mode_t MODE_UP    = 3'd3;
  localparam mode_t MODE_DOWN  = 3'd4;

  localparam logic [1:0] VEC_X = 2'd0;
  localparam logic [1:0] VEC_Y = 2'd1;
  localparam logic [1:0] VEC_Z = 2'd2;

  localparam logic [1:0] RES_X = 2'd0;
  localparam logic [1:0] RES_Y = 2'd1;
  localparam logic [1:0] RES_Z = 2'd2;

  localparam logic [3:0] FAC_ZERO = 4'd0;
  localparam logic [3:0] FAC_CY   = 4'd1;
  localparam logic [3:0] FAC_SY   = 4'd2;
  localparam logic [3:0] FAC_CX   = 4'd3;
  localparam logic [3:0] FAC_SX   = 4'd4;
  localparam logic [3:0] FAC_SS   = 4'd5;
  localparam logic [3:0] FAC_CS   = 4'd6;
  localparam logic [3:0] FAC_SC   = 4'd7;
  localparam logic [3:0] FAC_CC   = 4'd8;

  typedef struct packed {
    logic [1:0] vec_sel;
    logic [3:0] fac_sel;
    logic       sub;
    logic       first;
    logic       last;
    logic [1:0] res_idx;
  } term_op_t;

  // Restoring long division, evaluated only while the sine table is built.
  function automatic logic [63:0] div_u64(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] quo;
    logic [64:0] rem;
    quo = '0;
    rem = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[63:0], num[i]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  // Quarter-wave sine table, built at elaboration from a truncated Taylor series.
  function automatic sine_rom_t sine_rom_build();
    sine_rom_t   rom;
    logic [63:0] q;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] sum;
    logic [63:0] term;
    logic [63:0] val;
    int          n;
    q = (QUARTER_STEPS > 0) ? 64'(QUARTER_STEPS) : 64'd1;
    for (int k = 0; k <= QUARTER_STEPS; k++) begin
      x    = div_u64(PI_HALF_Q31 * 64'(k), q);
      x2   = (x * x) >> 31;
      sum  = x;
      term = x;
      n    = 1;
      while (n < 20 && term != 64'd0) begin
        term = div_u64((term * x2) >> 31, 64'(2 * n) * 64'(2 * n + 1));
        if (n[0]) begin
          sum = sum - term;
        end else begin
          sum = sum + term;
        end
        n++;
      end
      val = (sum + (64'd1 << (30 - TRIG_FRAC_BITS))) >> (31 - TRIG_FRAC_BITS);
      if (val > 64'(TRIG_ONE)) begin
        val = 64'(TRIG_ONE);
      end
      rom[k] = val[ROM_W-1:0];
    end
    return rom;
  endfunction

  localparam sine_rom_t SINE_ROM = sine_rom_build();

  function automatic term_op_t mk_term(input logic [1:0] vec_sel, input logic [3:0] fac_sel,
                                       input logic sub, input logic first, input logic last,
                                       input logic [1:0] res_idx);
    term_op_t r;
    r.vec_sel = vec_sel;
    r.fac_sel = fac_sel;
    r.sub     = sub;
    r.first   = first;
    r.last    = last;
    r.res_idx = res_idx;
    return r;
  endfunction

  // Nine multiply-accumulate terms, three for each rotated component.
  function automatic term_op_t term_op(input logic to_device, input logic [3:0] t);
    term_op_t r;
    r = '0;
    if (!to_device) begin
      unique case (t)
        4'd0:    r = mk_term(VEC_X, FAC_CY,   1'b0, 1'b1, 1'b0, RES_X);
        4'd1:    r = mk_term(VEC_Y, FAC_SS,   1'b0, 1'b0, 1'b0, RES_X);
        4'd2:    r = mk_term(VEC_Z, FAC_CS,   1'b1, 1'b0, 1'b1, RES_X);
        4'd3:    r = mk_term(VEC_Y, FAC_CX,   1'b0, 1'b1, 1'b0, RES_Y);
        4'd4:    r = mk_term(VEC_Z, FAC_SX,   1'b0, 1'b0, 1'b0, RES_Y);
        4'd5:    r = mk_term(VEC_X, FAC_ZERO, 1'b0, 1'b0, 1'b1, RES_Y);
        4'd6:    r = mk_term(VEC_X, FAC_SY,   1'b0, 1'b1, 1'b0, RES_Z);
        4'd7:    r = mk_term(VEC_Y, FAC_SC,   1'b1, 1'b0, 1'b0, RES_Z);
        4'd8:    r = mk_term(VEC_Z, FAC_CC,   1'b0, 1'b0, 1'b1, RES_Z);
        default: r = '0;
      endcase
    end else begin
      unique case (t)
        4'd0:    r = mk_term(VEC_X, FAC_CY,   1'b0, 1'b1, 1'b0, RES_X);
        4'd1:    r = mk_term(VEC_Z, FAC_SY,   1'b0, 1'b0, 1'b0, RES_X);
        4'd2:    r = mk_term(VEC_X, FAC_ZERO, 1'b0, 1'b0, 1'b1, RES_X);
        4'd3:    r = mk_term(VEC_X, FAC_SS,   1'b0, 1'b1, 1'b0, RES_Y);
        4'd4:    r = mk_term(VEC_Y, FAC_CX,   1'b0, 1'b0, 1'b0, RES_Y);
        4'd5:    r = mk_term(VEC_Z, FAC_SC,   1'b1, 1'b0, 1'b1, RES_Y);
        4'd6:    r = mk_term(VEC_Y, FAC_SX,   1'b0, 1'b1, 1'b0, RES_Z);
        4'd7:    r = mk_term(VEC_X, FAC_CS,   1'b1, 1'b0, 1'b0, RES_Z);
        4'd8:    r = mk_term(VEC_Z, FAC_CC,   1'b0, 1'b0, 1'b1, RES_Z);
        default: r = '0;
      endcase
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ rtl/tfr_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface tfr_in_if import tfr_pkg::*; ();
  logic    valid;
  logic    ready;
  action_t action;
  mode_t   hand_mode;
  vec_t    vec_x;
  vec_t    vec_y;
  vec_t    vec_z;

  modport source(output valid, action, hand_mode, vec_x, vec_y, vec_z, input ready);
  modport sink(input valid, action, hand_mode, vec_x, vec_y, vec_z, output ready);
endinterface

interface tfr_out_if import tfr_pkg::*; ();
  logic   valid;
  logic   ready;
  vec_t   out_x;
  vec_t   out_y;
  vec_t   out_z;
  yaw_t   yaw_now;
  pitch_t pitch_now;
  wheel_t wheel_level;
  mode_t  mode_now;

  modport source(output valid, out_x, out_y, out_z, yaw_now, pitch_now, wheel_level, mode_now,
                 input ready);
  modport sink(input valid, out_x, out_y, out_z, yaw_now, pitch_now, wheel_level, mode_now,
               output ready);
endinterface

`default_nettype wire

@@ rtl/turntable_frame_rotator_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake          Item
// in_chan   sink       valid/ready        action, hand_mode, vec_x, vec_y, vec_z
// out_chan  source     valid/ready        out_x, out_y, out_z, yaw_now, pitch_now,
//                                         wheel_level, mode_now
//
// A mode or wheel item goes straight to the done state, a rotation with unchanged angles runs
// the MAC sequence, and a tick that moves the turntable reads the sine ROM first.
// The 16-step multiply-accumulate sequence on the single 32x16 multiplier sets the rotation time.
// Reset is synchronous and active low; angles, wheel level, hand mode clear, trig to angle 0.
// A new item is accepted while a finished result waits in the output register; the next
// result stalls in its final state until that register is free.

module turntable_frame_rotator_unit import tfr_pkg::*; (
  input  wire        clk,
  input  wire        rst_n,
  tfr_in_if.sink     in_chan,
  tfr_out_if.source  out_chan
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_ROM  = 2'd1;
  localparam logic [1:0] ST_MAC  = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  localparam logic [1:0] K_NONE = 2'd0;
  localparam logic [1:0] K_TMUL = 2'd1;
  localparam logic [1:0] K_TERM = 2'd2;

  localparam logic [3:0] ROM_LAST   = 4'd4;
  localparam logic [3:0] TMUL_END   = 4'd4;
  localparam logic [3:0] TERM_FIRST = 4'd5;
  localparam logic [3:0] TERM_LAST  = 4'd13;
  localparam logic [3:0] MAC_LAST   = 4'd15;

  localparam logic signed [ANG_W-1:0] HALF_S   = ANG_W'(HALF_TURN_STEPS);
  localparam logic signed [ANG_W-1:0] TURN_S   = ANG_W'(2 * HALF_TURN_STEPS);
  localparam logic signed [ANG_W-1:0] PMAX_S   = ANG_W'(PITCH_MAX);
  localparam logic signed [ANG_W-1:0] PMIN_S   = ANG_W'(PITCH_MIN);
  localparam logic [ANG_W-1:0]        HALF_U   = ANG_W'(HALF_TURN_STEPS);
  localparam logic [ANG_W-1:0]        QUART_U  = ANG_W'(QUARTER_STEPS);
  localparam trig_t                   TRIG_ONE_T = TRIG_W'(TRIG_ONE);
  localparam vec_t VEC_MAX = {1'b0, {(VEC_W-1){1'b1}}};
  localparam vec_t VEC_MIN = {1'b1, {(VEC_W-1){1'b0}}};

  typedef struct packed {
    logic [ROM_AW-1:0] sin_idx;
    logic [ROM_AW-1:0] cos_idx;
    logic              sin_neg;
    logic              cos_neg;
  } trig_idx_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [1:0] tm_idx;
    term_op_t   op;
  } issue_t;

  function automatic trig_idx_t trig_index(input logic signed [ANG_W-1:0] a);
    trig_idx_t        r;
    logic [ANG_W-1:0] m;
    m         = a[ANG_W-1] ? ANG_W'(-a) : a;
    r.sin_neg = a[ANG_W-1];
    r.cos_neg = (m > QUART_U);
    r.sin_idx = (m > QUART_U) ? ROM_AW'(HALF_U - m) : ROM_AW'(m);
    r.cos_idx = (m > QUART_U) ? ROM_AW'(m - QUART_U) : ROM_AW'(QUART_U - m);
    return r;
  endfunction

  logic [1:0] state_r, state_nxt;
  logic [3:0] step_r, step_nxt;

  yaw_t   yaw_r;
  pitch_t pitch_r;
  wheel_t wheel_r;
  mode_t  mode_r;
  logic   to_dev_r;
  vec_t   vx_r, vy_r, vz_r;
  trig_t  ycos_r, ysin_r, pcos_r, psin_r;
  trig_t  ss_r, cs_r, sc_r, cc_r;
  vec_t   res_x_r, res_y_r, res_z_r;

  logic [ROM_W-1:0]  rom_q_r;
  logic [ROM_AW-1:0] rom_addr;
  trig_t             rom_s;
  trig_t             rom_val;
  logic              rom_neg;
  trig_idx_t         yaw_ix, pitch_ix;

  logic                      moves;
  logic signed [ANG_W-1:0]   yaw_sum, yaw_wrap, pitch_sum, pitch_clamp;
  logic signed [ANG_W-1:0]   yaw_hand, pitch_hand;

  vec_t                      mul_a;
  trig_t                     mul_b;
  logic signed [PROD_W-1:0]  prod_r;
  issue_t                    iss, s1_r;
  logic [3:0]                term_idx;
  term_op_t                  cur_op;
  logic signed [PROD_W-1:0]  tm_round;
  logic signed [ACC_W-1:0]   acc_r, prod_ext, acc_nxt;
  logic                      fin_v_r;
  logic [1:0]                fin_idx_r;
  logic signed [ACC_W-1:0]   fin_rnd;
  logic                      fin_ovf;
  vec_t                      fin_val;

  logic   in_fire, out_load, out_valid_r;
  vec_t   out_x_r, out_y_r, out_z_r;
  yaw_t   out_yaw_r;
  pitch_t out_pitch_r;
  wheel_t out_wheel_r;
  mode_t  out_mode_r;

  assign in_chan.ready = (state_r == ST_IDLE);
  assign in_fire       = in_chan.valid && in_chan.ready;
  assign out_load      = (state_r == ST_DONE) && (!out_valid_r || out_chan.ready);

  // Tick arithmetic on the stored angles.
  always_comb begin
    moves      = (mode_r != MODE_STOP) || (wheel_r != '0);
    yaw_hand   = (mode_r == MODE_RIGHT) ? ANG_W'(1) :
                 (mode_r == MODE_LEFT)  ? -ANG_W'(1) : '0;
    pitch_hand = (mode_r == MODE_DOWN)  ? ANG_W'(1) :
                 (mode_r == MODE_UP)    ? -ANG_W'(1) : '0;
    yaw_sum    = ANG_W'(yaw_r) + yaw_hand + ANG_W'(wheel_r) * ANG_W'(WHEEL_STEP);
    if (yaw_sum > HALF_S) begin
      yaw_wrap = yaw_sum - TURN_S;
    end else if (yaw_sum <= -HALF_S) begin
      yaw_wrap = yaw_sum + TURN_S;
    end else begin
      yaw_wrap = yaw_sum;
    end
    pitch_sum = ANG_W'(pitch_r) + pitch_hand;
    if (pitch_sum > PMAX_S) begin
      pitch_clamp = PMAX_S;
    end else if (pitch_sum < PMIN_S) begin
      pitch_clamp = PMIN_S;
    end else begin
      pitch_clamp = pitch_sum;
    end
  end

  // Sine ROM reads: yaw sine, yaw cosine, pitch sine, pitch cosine.
  always_comb begin
    yaw_ix   = trig_index(ANG_W'(yaw_r));
    pitch_ix = trig_index(ANG_W'(pitch_r));
    unique case (step_r[1:0])
      2'd0:    rom_addr = yaw_ix.sin_idx;
      2'd1:    rom_addr = yaw_ix.cos_idx;
      2'd2:    rom_addr = pitch_ix.sin_idx;
      default: rom_addr = pitch_ix.cos_idx;
    endcase
    unique case (step_r)
      4'd1:    rom_neg = yaw_ix.sin_neg;
      4'd2:    rom_neg = yaw_ix.cos_neg;
      4'd3:    rom_neg = pitch_ix.sin_neg;
      default: rom_neg = pitch_ix.cos_neg;
    endcase
    rom_s   = signed'(TRIG_W'(rom_q_r));
    rom_val = rom_neg ? -rom_s : rom_s;
  end

  always_ff @(posedge clk) begin
    rom_q_r <= SINE_ROM[rom_addr];
  end

  // Issue stage of the shared multiplier.
  always_comb begin
    mul_a    = '0;
    mul_b    = '0;
    iss      = '0;
    term_idx = step_r - TERM_FIRST;
    cur_op   = term_op(to_dev_r, term_idx);
    if (state_r == ST_MAC) begin
      if (step_r < TMUL_END) begin
        mul_a      = VEC_W'(step_r[0] ? pcos_r : psin_r);
        mul_b      = step_r[1] ? ycos_r : ysin_r;
        iss.kind   = K_TMUL;
        iss.tm_idx = step_r[1:0];
      end else if (step_r >= TERM_FIRST && step_r <= TERM_LAST) begin
        unique case (cur_op.vec_sel)
          VEC_X:   mul_a = vx_r;
          VEC_Y:   mul_a = vy_r;
          default: mul_a = vz_r;
        endcase
        unique case (cur_op.fac_sel)
          FAC_CY:  mul_b = ycos_r;
          FAC_SY:  mul_b = ysin_r;
          FAC_CX:  mul_b = pcos_r;
          FAC_SX:  mul_b = psin_r;
          FAC_SS:  mul_b = ss_r;
          FAC_CS:  mul_b = cs_r;
          FAC_SC:  mul_b = sc_r;
          FAC_CC:  mul_b = cc_r;
          default: mul_b = '0;
        endcase
        iss.kind = K_TERM;
        iss.op   = cur_op;
      end
    end
  end

  // Writeback, accumulate and final rounding with saturation.
  always_comb begin
    tm_round = (prod_r + PROD_W'(ROUND_HALF)) >>> TRIG_FRAC_BITS;
    prod_ext = ACC_W'(prod_r);
    if (s1_r.op.first) begin
      acc_nxt = prod_ext;
    end else if (s1_r.op.sub) begin
      acc_nxt = acc_r - prod_ext;
    end else begin
      acc_nxt = acc_r + prod_ext;
    end
    fin_rnd = (acc_r + ACC_W'(ROUND_HALF)) >>> TRIG_FRAC_BITS;
    fin_ovf = !(&fin_rnd[ACC_W-1:VEC_W-1]) && (|fin_rnd[ACC_W-1:VEC_W-1]);
    if (fin_ovf) begin
      fin_val = fin_rnd[ACC_W-1] ? VEC_MIN : VEC_MAX;
    end else begin
      fin_val = fin_rnd[VEC_W-1:0];
    end
  end

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          step_nxt = '0;
          if (in_chan.action == ACT_TICK) begin
            state_nxt = moves ? ST_ROM : ST_MAC;
          end else if (in_chan.action == ACT_DEVICE) begin
            state_nxt = ST_MAC;
          end else begin
            state_nxt = ST_DONE;
          end
        end
      end
      ST_ROM: begin
        if (step_r == ROM_LAST) begin
          state_nxt = ST_MAC;
          step_nxt  = '0;
        end else begin
          step_nxt = step_r + 4'd1;
        end
      end
      ST_MAC: begin
        if (step_r == MAC_LAST) begin
          state_nxt = ST_DONE;
        end else begin
          step_nxt = step_r + 4'd1;
        end
      end
      default: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      yaw_r       <= '0;
      pitch_r     <= '0;
      wheel_r     <= '0;
      mode_r      <= MODE_STOP;
      ycos_r      <= TRIG_ONE_T;
      ysin_r      <= '0;
      pcos_r      <= TRIG_ONE_T;
      psin_r      <= '0;
      s1_r        <= '0;
      fin_v_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      s1_r    <= iss;
      fin_v_r <= (s1_r.kind == K_TERM) && s1_r.op.last;
      if (in_fire) begin
        unique case (in_chan.action)
          ACT_TICK: begin
            if (moves) begin
              yaw_r   <= yaw_wrap[YAW_W-1:0];
              pitch_r <= pitch_clamp[PITCH_W-1:0];
            end
          end
          ACT_MODE: begin
            if (in_chan.hand_mode <= MODE_DOWN &&
                (wheel_r == '0 || in_chan.hand_mode == MODE_UP ||
                 in_chan.hand_mode == MODE_DOWN || in_chan.hand_mode == MODE_STOP)) begin
              mode_r <= in_chan.hand_mode;
            end
          end
          ACT_WHEEL_UP: begin
            mode_r <= MODE_STOP;
            if (wheel_r < wheel_t'(WHEEL_MAX)) begin
              wheel_r <= wheel_r + 3'd1;
            end
          end
          ACT_WHEEL_DOWN: begin
            if (wheel_r != '0) begin
              wheel_r <= wheel_r - 3'd1;
            end
          end
          default: begin
          end
        endcase
      end
      if (state_r == ST_ROM) begin
        unique case (step_r)
          4'd1:    ysin_r <= rom_val;
          4'd2:    ycos_r <= rom_val;
          4'd3:    psin_r <= rom_val;
          4'd4:    pcos_r <= rom_val;
          default: begin
          end
        endcase
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= PROD_W'(mul_a) * PROD_W'(mul_b);
    if (in_fire) begin
      vx_r     <= in_chan.vec_x;
      vy_r     <= in_chan.vec_y;
      vz_r     <= in_chan.vec_z;
      to_dev_r <= (in_chan.action == ACT_DEVICE);
      res_x_r  <= '0;
      res_y_r  <= '0;
      res_z_r  <= '0;
    end
    if (s1_r.kind == K_TMUL) begin
      unique case (s1_r.tm_idx)
        2'd0:    ss_r <= tm_round[TRIG_W-1:0];
        2'd1:    cs_r <= tm_round[TRIG_W-1:0];
        2'd2:    sc_r <= tm_round[TRIG_W-1:0];
        default: cc_r <= tm_round[TRIG_W-1:0];
      endcase
    end
    if (s1_r.kind == K_TERM) begin
      acc_r     <= acc_nxt;
      fin_idx_r <= s1_r.op.res_idx;
    end
    if (fin_v_r) begin
      unique case (fin_idx_r)
        RES_X:   res_x_r <= fin_val;
        RES_Y:   res_y_r <= fin_val;
        default: res_z_r <= fin_val;
      endcase
    end
    if (out_load) begin
      out_x_r     <= res_x_r;
      out_y_r     <= res_y_r;
      out_z_r     <= res_z_r;
      out_yaw_r   <= yaw_r;
      out_pitch_r <= pitch_r;
      out_wheel_r <= wheel_r;
      out_mode_r  <= mode_r;
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.out_x       = out_x_r;
  assign out_chan.out_y       = out_y_r;
  assign out_chan.out_z       = out_z_r;
  assign out_chan.yaw_now     = out_yaw_r;
  assign out_chan.pitch_now   = out_pitch_r;
  assign out_chan.wheel_level = out_wheel_r;
  assign out_chan.mode_now    = out_mode_r;

  a_pitch_range: assert property (@(posedge clk) disable iff (!rst_n)
    (pitch_r >= pitch_t'(PITCH_MIN)) && (pitch_r <= pitch_t'(PITCH_MAX)))
    else $error("pitch left its clamp range");

  a_yaw_range: assert property (@(posedge clk) disable iff (!rst_n)
    (yaw_r > -yaw_t'(HALF_TURN_STEPS)) && (yaw_r <= yaw_t'(HALF_TURN_STEPS)))
    else $error("yaw left its wrap range");

  a_wheel_range: assert property (@(posedge clk) disable iff (!rst_n)
    wheel_r <= wheel_t'(WHEEL_MAX))
    else $error("wheel level above its maximum");

  a_mac_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MAC && step_r == MAC_LAST) |=> (state_r == ST_DONE))
    else $error("rotation sequence did not finish");

  a_ctrl_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_chan.action != ACT_TICK && in_chan.action != ACT_DEVICE) |=>
    (state_r == ST_DONE && res_x_r == '0 && res_y_r == '0 && res_z_r == '0))
    else $error("control item did not clear the rotated vector");

endmodule

`default_nettype wire
